@@ rtl/tls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_pkg
// Shared codes, sequencer operations and the control/status bundles of the
// three-level task scheduler.
// ----------------------------------------------------------------------------
package tls_pkg;

    localparam int MAX_TASKS_DEF = 8;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_YIELD  = 3'd2;
    localparam logic [2:0] CMD_TERM   = 3'd3;
    localparam logic [2:0] CMD_GETARG = 3'd4;

    // task levels / classes
    localparam logic [1:0] CL_SYS  = 2'd0;
    localparam logic [1:0] CL_PER  = 2'd1;
    localparam logic [1:0] CL_RR   = 2'd2;
    localparam logic [1:0] CL_IDLE = 2'd3;

    // task status
    localparam logic [1:0] ST_DEAD  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // queue identifiers
    localparam logic [1:0] Q_FREE = 2'd0;
    localparam logic [1:0] Q_SYS  = 2'd1;
    localparam logic [1:0] Q_RR   = 2'd2;
    localparam logic [1:0] Q_PER  = 2'd3;

    // fault codes
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_OVERRUN = 2'd1;
    localparam logic [1:0] FAULT_BADCMD  = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_TICK     = 4'd2,
        OP_BUDGET   = 4'd3,
        OP_SCAN     = 4'd4,
        OP_REQUEUE  = 4'd5,
        OP_FAULT    = 4'd6,
        OP_CPOP     = 4'd7,
        OP_CPUSH    = 4'd8,
        OP_CREQ     = 4'd9,
        OP_YIELD    = 4'd10,
        OP_RMINIT   = 4'd11,
        OP_RMSTEP   = 4'd12,
        OP_TERM     = 4'd13,
        OP_DISPATCH = 4'd14,
        OP_OUTPUT   = 4'd15
    } op_t;

    typedef struct packed {
        op_t  op;
        logic s_ready;
    } tls_ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] lvl;
        logic       free_empty;
        logic       cur_idle;
        logic       cur_is_per;
        logic       act_valid;
        logic       scan_end;
        logic       rm_end;
        logic       out_free;
    } tls_stat_t;

endpackage
`default_nettype wire

@@ rtl/tls_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_ctrl
// Sequencer: steps one command word through the datapath operations.
// ----------------------------------------------------------------------------
module tls_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire tls_pkg::tls_stat_t stat,
    output tls_pkg::tls_ctl_t      ctl
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DECODE   = 16'h0002,
        S_TICK     = 16'h0004,
        S_BUDGET   = 16'h0008,
        S_SCAN     = 16'h0010,
        S_REQUEUE  = 16'h0020,
        S_FAULT    = 16'h0040,
        S_CPOP     = 16'h0080,
        S_CPUSH    = 16'h0100,
        S_CREQ     = 16'h0200,
        S_YIELD    = 16'h0400,
        S_RMINIT   = 16'h0800,
        S_RMSTEP   = 16'h1000,
        S_TERM     = 16'h2000,
        S_DISPATCH = 16'h4000,
        S_OUTPUT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequence the operations of one command
    always_comb begin
        state_next  = state_reg;
        ctl.op      = tls_pkg::OP_NONE;
        ctl.s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                ctl.s_ready = 1'b1;
                if (s_valid) begin
                    ctl.op     = tls_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.cmd)
                    tls_pkg::CMD_TICK: begin
                        state_next = S_TICK;
                    end
                    tls_pkg::CMD_CREATE: begin
                        if (stat.lvl == tls_pkg::CL_IDLE) begin
                            state_next = S_FAULT;
                        end else if (stat.free_empty) begin
                            state_next = S_DISPATCH;
                        end else begin
                            state_next = S_CPOP;
                        end
                    end
                    tls_pkg::CMD_YIELD: begin
                        state_next = S_YIELD;
                    end
                    tls_pkg::CMD_TERM: begin
                        if (stat.cur_idle) begin
                            state_next = S_DISPATCH;
                        end else if (stat.cur_is_per) begin
                            state_next = S_RMINIT;
                        end else begin
                            state_next = S_TERM;
                        end
                    end
                    tls_pkg::CMD_GETARG: begin
                        state_next = S_DISPATCH;
                    end
                    default: begin
                        state_next = S_FAULT;
                    end
                endcase
            end
            S_TICK: begin
                ctl.op     = tls_pkg::OP_TICK;
                state_next = stat.act_valid ? S_BUDGET : S_SCAN;
            end
            S_BUDGET: begin
                ctl.op     = tls_pkg::OP_BUDGET;
                state_next = S_REQUEUE;
            end
            S_SCAN: begin
                ctl.op = tls_pkg::OP_SCAN;
                if (stat.scan_end) begin
                    state_next = S_REQUEUE;
                end
            end
            S_REQUEUE: begin
                ctl.op     = tls_pkg::OP_REQUEUE;
                state_next = S_DISPATCH;
            end
            S_FAULT: begin
                ctl.op     = tls_pkg::OP_FAULT;
                state_next = S_DISPATCH;
            end
            S_CPOP: begin
                ctl.op     = tls_pkg::OP_CPOP;
                state_next = S_CPUSH;
            end
            S_CPUSH: begin
                ctl.op     = tls_pkg::OP_CPUSH;
                state_next = S_CREQ;
            end
            S_CREQ: begin
                ctl.op     = tls_pkg::OP_CREQ;
                state_next = S_DISPATCH;
            end
            S_YIELD: begin
                ctl.op     = tls_pkg::OP_YIELD;
                state_next = S_DISPATCH;
            end
            S_RMINIT: begin
                ctl.op     = tls_pkg::OP_RMINIT;
                state_next = S_RMSTEP;
            end
            S_RMSTEP: begin
                ctl.op = tls_pkg::OP_RMSTEP;
                if (stat.rm_end) begin
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                ctl.op     = tls_pkg::OP_TERM;
                state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                ctl.op     = tls_pkg::OP_DISPATCH;
                state_next = S_OUTPUT;
            end
            S_OUTPUT: begin
                if (stat.out_free) begin
                    ctl.op     = tls_pkg::OP_OUTPUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/tls_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_datapath
// Task descriptors, linked queues, periodic bookkeeping and output register.
// ----------------------------------------------------------------------------
module tls_datapath #(
    parameter int MAX_TASKS = tls_pkg::MAX_TASKS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tls_pkg::tls_ctl_t                   ctl,
    output tls_pkg::tls_stat_t                       stat,
    input  wire logic [2:0]                          s_command,
    input  wire logic [1:0]                          s_new_level,
    input  wire logic signed [15:0]                  s_new_arg,
    input  wire logic [15:0]                         s_new_period,
    input  wire logic [15:0]                         s_new_budget,
    input  wire logic [15:0]                         s_new_start,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [$clog2(MAX_TASKS+1)-1:0]           m_running_task,
    output logic                                     m_create_ok,
    output logic [$clog2(MAX_TASKS)-1:0]             m_created_task,
    output logic signed [15:0]                       m_running_arg,
    output logic [1:0]                               m_fault
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int TW = $clog2(MAX_TASKS + 1);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [TW-1:0] IDLE_IX = TW'(MAX_TASKS);

    // latched command word
    logic [2:0]  cmd_reg;
    logic [1:0]  lvl_reg;
    logic [15:0] arg_in_reg, period_in_reg, budget_in_reg, start_in_reg;

    // descriptors
    logic [1:0]    status_reg [MAX_TASKS];
    logic [1:0]    status_next[MAX_TASKS];
    logic [1:0]    class_reg  [MAX_TASKS];
    logic [1:0]    class_next [MAX_TASKS];
    logic [15:0]   arg_reg    [MAX_TASKS];
    logic [15:0]   arg_next   [MAX_TASKS];
    logic [15:0]   period_reg [MAX_TASKS];
    logic [15:0]   period_next[MAX_TASKS];
    logic [15:0]   budget_reg [MAX_TASKS];
    logic [15:0]   budget_next[MAX_TASKS];
    logic [15:0]   due_reg    [MAX_TASKS];
    logic [15:0]   due_next   [MAX_TASKS];
    logic [IW-1:0] link_reg   [MAX_TASKS];
    logic [IW-1:0] link_next  [MAX_TASKS];

    // queue heads, tails and counts
    logic [IW-1:0] head_reg[4];
    logic [IW-1:0] head_next[4];
    logic [IW-1:0] tail_reg[4];
    logic [IW-1:0] tail_next[4];
    logic [CW-1:0] cnt_reg[4];
    logic [CW-1:0] cnt_next[4];

    // scheduler state
    logic [TW-1:0] cur_reg, cur_next;
    logic          act_valid_reg, act_valid_next;
    logic [IW-1:0] act_ix_reg, act_ix_next;
    logic [15:0]   tick_reg, tick_next;
    logic [15:0]   onset_reg, onset_next;
    logic [1:0]    fault_reg, fault_next;
    logic          ok_reg, ok_next;
    logic [IW-1:0] made_reg, made_next;

    // list walk pointers
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [CW-1:0] idx_reg, idx_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [TW-1:0] out_task_reg, out_task_next;
    logic          out_ok_reg, out_ok_next;
    logic [IW-1:0] out_made_reg, out_made_next;
    logic [15:0]   out_arg_reg, out_arg_next;
    logic [1:0]    out_fault_reg, out_fault_next;

    // derived values
    logic [IW-1:0] cur_ix;
    logic          cur_idle;
    logic [1:0]    cur_class;
    logic [1:0]    cur_status;
    logic          need_pick;
    logic          scan_hit;
    logic          scan_end;
    logic          rm_end;
    logic [15:0]   since;

    // queue request
    logic          push_en;
    logic [1:0]    push_q;
    logic [IW-1:0] push_t;
    logic          pop_en;
    logic [1:0]    pop_q;
    logic [1:0]    q_sel;
    logic [IW-1:0] pop_t;
    logic [IW-1:0] link_raddr;
    logic [IW-1:0] link_rd;

    assign cur_ix     = cur_reg[IW-1:0];
    assign cur_idle   = (cur_reg == IDLE_IX);
    assign cur_class  = cur_idle ? tls_pkg::CL_IDLE : class_reg[cur_ix];
    assign cur_status = status_reg[cur_ix];
    assign need_pick  = cur_idle || (cur_status != tls_pkg::ST_RUN);
    assign since      = 16'(tick_reg - onset_reg);
    assign scan_hit   = 16'(due_reg[ptr_reg] - tick_reg) > period_reg[ptr_reg];
    assign scan_end   = (idx_reg == cnt_reg[tls_pkg::Q_PER]) || scan_hit;
    assign rm_end     = (idx_reg == cnt_reg[tls_pkg::Q_PER]) || (ptr_reg == cur_ix);

    // status to the controller
    assign stat.cmd        = cmd_reg;
    assign stat.lvl        = lvl_reg;
    assign stat.free_empty = (cnt_reg[tls_pkg::Q_FREE] == '0);
    assign stat.cur_idle   = cur_idle;
    assign stat.cur_is_per = (cur_class == tls_pkg::CL_PER);
    assign stat.act_valid  = act_valid_reg;
    assign stat.scan_end   = scan_end;
    assign stat.rm_end     = rm_end;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // pick the queue operation of this step
    always_comb begin
        push_en = 1'b0;
        push_q  = tls_pkg::Q_FREE;
        push_t  = cur_ix;
        pop_en  = 1'b0;
        pop_q   = tls_pkg::Q_FREE;
        case (ctl.op)
            tls_pkg::OP_REQUEUE: begin
                if (cur_class == tls_pkg::CL_RR && cur_status == tls_pkg::ST_RUN) begin
                    push_en = 1'b1;
                    push_q  = tls_pkg::Q_RR;
                end
            end
            tls_pkg::OP_CPOP: begin
                pop_en = 1'b1;
                pop_q  = tls_pkg::Q_FREE;
            end
            tls_pkg::OP_CPUSH: begin
                push_en = 1'b1;
                push_t  = made_reg;
                if (lvl_reg == tls_pkg::CL_SYS) begin
                    push_q = tls_pkg::Q_SYS;
                end else if (lvl_reg == tls_pkg::CL_PER) begin
                    push_q = tls_pkg::Q_PER;
                end else begin
                    push_q = tls_pkg::Q_RR;
                end
            end
            tls_pkg::OP_CREQ: begin
                if (cur_class == tls_pkg::CL_RR && cur_status == tls_pkg::ST_READY) begin
                    push_en = 1'b1;
                    push_q  = tls_pkg::Q_RR;
                end
            end
            tls_pkg::OP_YIELD: begin
                if (cur_class == tls_pkg::CL_SYS) begin
                    push_en = 1'b1;
                    push_q  = tls_pkg::Q_SYS;
                end else if (cur_class == tls_pkg::CL_RR) begin
                    push_en = 1'b1;
                    push_q  = tls_pkg::Q_RR;
                end
            end
            tls_pkg::OP_TERM: begin
                push_en = 1'b1;
                push_q  = tls_pkg::Q_FREE;
            end
            tls_pkg::OP_DISPATCH: begin
                if (need_pick) begin
                    if (cnt_reg[tls_pkg::Q_SYS] != '0) begin
                        pop_en = 1'b1;
                        pop_q  = tls_pkg::Q_SYS;
                    end else if (!act_valid_reg && cnt_reg[tls_pkg::Q_RR] != '0) begin
                        pop_en = 1'b1;
                        pop_q  = tls_pkg::Q_RR;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // one queue and one link read port per step
    assign q_sel      = pop_en ? pop_q : push_q;
    assign pop_t      = head_reg[q_sel];
    assign link_raddr = (ctl.op == tls_pkg::OP_SCAN || ctl.op == tls_pkg::OP_RMSTEP)
                        ? ptr_reg : pop_t;
    assign link_rd    = link_reg[link_raddr];

    // next state of the datapath
    always_comb begin
        status_next    = status_reg;
        class_next     = class_reg;
        arg_next       = arg_reg;
        period_next    = period_reg;
        budget_next    = budget_reg;
        due_next       = due_reg;
        link_next      = link_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        act_valid_next = act_valid_reg;
        act_ix_next    = act_ix_reg;
        tick_next      = tick_reg;
        onset_next     = onset_reg;
        fault_next     = fault_reg;
        ok_next        = ok_reg;
        made_next      = made_reg;
        ptr_next       = ptr_reg;
        prev_next      = prev_reg;
        idx_next       = idx_reg;
        out_task_next  = out_task_reg;
        out_ok_next    = out_ok_reg;
        out_made_next  = out_made_reg;
        out_arg_next   = out_arg_reg;
        out_fault_next = out_fault_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (ctl.op)
            tls_pkg::OP_LOAD: begin
                ok_next   = 1'b0;
                made_next = '0;
            end
            tls_pkg::OP_TICK: begin
                tick_next = 16'(tick_reg + 16'd1);
                ptr_next  = head_reg[tls_pkg::Q_PER];
                idx_next  = '0;
            end
            tls_pkg::OP_BUDGET: begin
                if (since > budget_reg[act_ix_reg] && fault_reg == tls_pkg::FAULT_NONE) begin
                    fault_next = tls_pkg::FAULT_OVERRUN;
                end
            end
            tls_pkg::OP_SCAN: begin
                if (idx_reg != cnt_reg[tls_pkg::Q_PER]) begin
                    if (scan_hit) begin
                        act_valid_next    = 1'b1;
                        act_ix_next       = ptr_reg;
                        onset_next        = tick_reg;
                        due_next[ptr_reg] = 16'(due_reg[ptr_reg] + period_reg[ptr_reg]);
                    end else begin
                        ptr_next = link_rd;
                        idx_next = CW'(idx_reg + 1'b1);
                    end
                end
            end
            tls_pkg::OP_REQUEUE: begin
                if (cur_class == tls_pkg::CL_RR && cur_status == tls_pkg::ST_RUN) begin
                    status_next[cur_ix] = tls_pkg::ST_READY;
                end
            end
            tls_pkg::OP_FAULT: begin
                if (fault_reg == tls_pkg::FAULT_NONE) begin
                    fault_next = tls_pkg::FAULT_BADCMD;
                end
            end
            tls_pkg::OP_CPOP: begin
                made_next          = pop_t;
                ok_next            = 1'b1;
                status_next[pop_t] = tls_pkg::ST_READY;
                class_next[pop_t]  = lvl_reg;
                arg_next[pop_t]    = arg_in_reg;
                period_next[pop_t] = period_in_reg;
                budget_next[pop_t] = budget_in_reg;
                due_next[pop_t]    = start_in_reg;
            end
            tls_pkg::OP_CPUSH: begin
                // a new system task preempts a non-system task
                if (lvl_reg == tls_pkg::CL_SYS && cur_class != tls_pkg::CL_SYS && !cur_idle) begin
                    status_next[cur_ix] = tls_pkg::ST_READY;
                end
            end
            tls_pkg::OP_YIELD: begin
                if (!cur_idle) begin
                    status_next[cur_ix] = tls_pkg::ST_READY;
                    if (cur_class == tls_pkg::CL_PER && act_valid_reg && act_ix_reg == cur_ix) begin
                        act_valid_next = 1'b0;
                    end
                end
            end
            tls_pkg::OP_RMINIT: begin
                ptr_next  = head_reg[tls_pkg::Q_PER];
                prev_next = '0;
                idx_next  = '0;
            end
            tls_pkg::OP_RMSTEP: begin
                // unlink the running task from the periodic list
                if (idx_reg != cnt_reg[tls_pkg::Q_PER]) begin
                    if (ptr_reg == cur_ix) begin
                        if (idx_reg == '0) begin
                            head_next[tls_pkg::Q_PER] = link_rd;
                        end else begin
                            link_next[prev_reg] = link_rd;
                            if (idx_reg == CW'(cnt_reg[tls_pkg::Q_PER] - 1'b1)) begin
                                tail_next[tls_pkg::Q_PER] = prev_reg;
                            end
                        end
                        cnt_next[tls_pkg::Q_PER] = CW'(cnt_reg[tls_pkg::Q_PER] - 1'b1);
                    end else begin
                        prev_next = ptr_reg;
                        ptr_next  = link_rd;
                        idx_next  = CW'(idx_reg + 1'b1);
                    end
                end
            end
            tls_pkg::OP_TERM: begin
                status_next[cur_ix] = tls_pkg::ST_DEAD;
                if (cur_class == tls_pkg::CL_PER && act_valid_reg && act_ix_reg == cur_ix) begin
                    act_valid_next = 1'b0;
                end
            end
            tls_pkg::OP_DISPATCH: begin
                if (need_pick) begin
                    if (pop_en) begin
                        cur_next           = TW'(pop_t);
                        status_next[pop_t] = tls_pkg::ST_RUN;
                    end else if (act_valid_reg) begin
                        cur_next                = TW'(act_ix_reg);
                        status_next[act_ix_reg] = tls_pkg::ST_RUN;
                    end else begin
                        cur_next = IDLE_IX;
                    end
                end
            end
            tls_pkg::OP_OUTPUT: begin
                out_task_next  = cur_reg;
                out_ok_next    = ok_reg;
                out_made_next  = made_reg;
                out_arg_next   = cur_idle ? 16'd0 : arg_reg[cur_ix];
                out_fault_next = fault_reg;
                m_valid_next   = 1'b1;
            end
            default: begin
            end
        endcase

        // apply the queue push or pop
        if (push_en) begin
            if (cnt_reg[q_sel] == '0) begin
                head_next[q_sel] = push_t;
            end else begin
                link_next[tail_reg[q_sel]] = push_t;
            end
            tail_next[q_sel] = push_t;
            cnt_next[q_sel]  = CW'(cnt_reg[q_sel] + 1'b1);
        end
        if (pop_en) begin
            cnt_next[q_sel] = CW'(cnt_reg[q_sel] - 1'b1);
            if (cnt_reg[q_sel] != CW'(1)) begin
                head_next[q_sel] = link_rd;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                status_reg[i] <= (i == 0) ? tls_pkg::ST_RUN : tls_pkg::ST_DEAD;
                class_reg[i]  <= tls_pkg::CL_SYS;
                arg_reg[i]    <= '0;
                link_reg[i]   <= (i < MAX_TASKS - 1) ? IW'(i + 1) : '0;
            end
            // free pool holds 1..MAX_TASKS-1, other queues empty
            for (int q = 0; q < 4; q++) begin
                head_reg[q] <= (q == int'(tls_pkg::Q_FREE)) ? IW'(1) : '0;
                tail_reg[q] <= (q == int'(tls_pkg::Q_FREE)) ? IW'(MAX_TASKS - 1) : '0;
                cnt_reg[q]  <= (q == int'(tls_pkg::Q_FREE)) ? CW'(MAX_TASKS - 1) : '0;
            end
            cur_reg       <= '0;
            act_valid_reg <= 1'b0;
            act_ix_reg    <= '0;
            tick_reg      <= '0;
            onset_reg     <= '0;
            fault_reg     <= tls_pkg::FAULT_NONE;
            ok_reg        <= 1'b0;
            made_reg      <= '0;
            ptr_reg       <= '0;
            prev_reg      <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            out_task_reg  <= '0;
            out_ok_reg    <= 1'b0;
            out_made_reg  <= '0;
            out_arg_reg   <= '0;
            out_fault_reg <= tls_pkg::FAULT_NONE;
        end else begin
            status_reg    <= status_next;
            class_reg     <= class_next;
            arg_reg       <= arg_next;
            link_reg      <= link_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            act_valid_reg <= act_valid_next;
            act_ix_reg    <= act_ix_next;
            tick_reg      <= tick_next;
            onset_reg     <= onset_next;
            fault_reg     <= fault_next;
            ok_reg        <= ok_next;
            made_reg      <= made_next;
            ptr_reg       <= ptr_next;
            prev_reg      <= prev_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
            out_task_reg  <= out_task_next;
            out_ok_reg    <= out_ok_next;
            out_made_reg  <= out_made_next;
            out_arg_reg   <= out_arg_next;
            out_fault_reg <= out_fault_next;
        end
    end

    // payload: periodic descriptor fields and the latched command word
    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        budget_reg <= budget_next;
        due_reg    <= due_next;
        if (ctl.op == tls_pkg::OP_LOAD) begin
            cmd_reg       <= s_command;
            lvl_reg       <= s_new_level;
            arg_in_reg    <= s_new_arg;
            period_in_reg <= s_new_period;
            budget_in_reg <= s_new_budget;
            start_in_reg  <= s_new_start;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_running_task = out_task_reg;
    assign m_create_ok    = out_ok_reg;
    assign m_created_task = out_made_reg;
    assign m_running_arg  = out_arg_reg;
    assign m_fault        = out_fault_reg;

endmodule
`default_nettype wire

@@ rtl/three_level_task_scheduler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_task_scheduler_core
// Task scheduler with system, periodic and round-robin levels.
// ----------------------------------------------------------------------------
// One command word at a time is taken, handled and answered with one result
// word. After decode, a get argument or a create with no free descriptor goes
// straight to dispatch; a yield, a plain terminate or a bad command first takes
// its yield, terminate or fault step; a create pops, pushes and requeues; a
// tick with an active periodic task ticks, checks the budget and requeues. A
// tick with no active periodic task scans the periodic list entry by entry up
// to a due entry or the list end, and terminating a periodic task walks the
// list up to and including its own entry to unlink it. The sequencer steps
// through the linked queues over a single link read port.
// A new command word is taken while the previous result word still waits on
// the output register; the next result then holds in the last sequencer step
// until that word is taken.
module three_level_task_scheduler_core #(
    parameter int MAX_TASKS = tls_pkg::MAX_TASKS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    s_command,
    input  wire logic [1:0]                    s_new_level,
    input  wire logic signed [15:0]            s_new_arg,
    input  wire logic [15:0]                   s_new_period,
    input  wire logic [15:0]                   s_new_budget,
    input  wire logic [15:0]                   s_new_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [$clog2(MAX_TASKS+1)-1:0]     m_running_task,
    output logic                               m_create_ok,
    output logic [$clog2(MAX_TASKS)-1:0]       m_created_task,
    output logic signed [15:0]                 m_running_arg,
    output logic [1:0]                         m_fault
);

    tls_pkg::tls_ctl_t  ctl;
    tls_pkg::tls_stat_t stat;

    // sequencer
    tls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctl     (ctl)
    );

    // scheduler state and queues
    tls_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .stat           (stat),
        .s_command      (s_command),
        .s_new_level    (s_new_level),
        .s_new_arg      (s_new_arg),
        .s_new_period   (s_new_period),
        .s_new_budget   (s_new_budget),
        .s_new_start    (s_new_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_running_task (m_running_task),
        .m_create_ok    (m_create_ok),
        .m_created_task (m_created_task),
        .m_running_arg  (m_running_arg),
        .m_fault        (m_fault)
    );

    assign s_ready = ctl.s_ready;

    // one word in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command word accepted while another is in work");

    // a reported fault never changes
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fault != tls_pkg::FAULT_NONE) |=> (m_fault == $past(m_fault)))
        else $error("sticky fault changed");

    // failed create reports descriptor zero
    a_made_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_create_ok) |-> (m_created_task == '0))
        else $error("created task nonzero without create success");

    // running task is a descriptor or idle
    a_task_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_running_task <= MAX_TASKS))
        else $error("running task out of range");

endmodule
`default_nettype wire
